// ----- rtl/vgm_pkg.sv -----
// Shared types, constants and state codes for the voxel group mode selector.
package vgm_pkg;

  // Field widths.
  localparam int TYPE_W  = 16;
  localparam int LAYER_W = 3;
  localparam int CNT_W   = 10;
  localparam int GS_W    = 4;

  // Store geometry.
  localparam int TYPE_DEPTH = 2 ** TYPE_W;
  localparam int SEEN_DEPTH = 512;
  localparam int TOT_W      = $clog2(SEEN_DEPTH) + 1;

  typedef logic [TYPE_W-1:0]  type_t;
  typedef logic [LAYER_W-1:0] layer_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [GS_W-1:0]    gs_t;
  typedef logic [TOT_W-1:0]   tot_t;

  // Limits and reset values.
  localparam cnt_t CNT_MAX   = '1;
  localparam tot_t SEEN_FULL = tot_t'(SEEN_DEPTH);
  localparam gs_t  GS_MIN    = gs_t'(2);
  localparam gs_t  GS_MAX    = gs_t'(8);
  localparam gs_t  GS_RESET  = gs_t'(2);
  localparam type_t AIR      = '0;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_CLR    = 7'b0000001,
    ST_RUN    = 7'b0000010,
    ST_TOPRD  = 7'b0000100,
    ST_TOPCAP = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_SWEEP  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage

// ----- rtl/vgm_in_if.sv -----
// Voxel request channel: valid, ready and one voxel of a group.
interface vgm_in_if;
  logic            valid;
  logic            ready;
  vgm_pkg::type_t  block_type;
  vgm_pkg::layer_t layer;
  logic            last_voxel;

  modport source (output valid, output block_type, output layer, output last_voxel,
                  input ready);
  modport sink (input valid, input block_type, input layer, input last_voxel,
                output ready);
endinterface

// ----- rtl/vgm_out_if.sv -----
// Result request channel: valid, ready and the representative of one group.
interface vgm_out_if;
  logic           valid;
  logic           ready;
  vgm_pkg::type_t representative_type;
  logic           surface_rule_used;
  vgm_pkg::cnt_t  winning_count;

  modport source (output valid, output representative_type, output surface_rule_used,
                  output winning_count, input ready);
  modport sink (input valid, input representative_type, input surface_rule_used,
                input winning_count, output ready);
endinterface

// ----- rtl/vgm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
module vgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- rtl/voxel_group_mode_with_top_preference_top.sv -----
// Top level of the voxel group representative selector.
// Throughput: one voxel per cycle within a group; once the last voxel is taken, the result
// enters the output register after a walk over the seen-type RAM and the count RAM that
// visits each listed distinct non-air type, and only once the output register is free.
// A group with more than 512 distinct non-air types adds a count RAM clearing sweep.
// Reset: synchronous, active low; a pass then zeroes the count RAM, no voxel taken.
module voxel_group_mode_with_top_preference_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  vgm_pkg::gs_t         cfg_wdata,
  vgm_in_if.sink               in_if,
  vgm_out_if.source            out_if
);

  vgm_pkg::state_t state_r, state_nxt;

  // Configuration.
  vgm_pkg::gs_t gs_r;

  // Input stage: voxel whose count read is in flight.
  logic            s1_v_r, s1_v_nxt;
  vgm_pkg::type_t  s1_kind_r;
  vgm_pkg::layer_t s1_layer_r;
  logic            s1_last_r;

  // Group state.
  vgm_pkg::tot_t   seen_total_r, seen_total_nxt;
  logic            top_found_r, top_found_nxt;
  vgm_pkg::layer_t top_layer_r, top_layer_nxt;
  vgm_pkg::type_t  top_kind_r, top_kind_nxt;
  logic            ovf_r, ovf_nxt;

  // Decision state.
  vgm_pkg::cnt_t   top_cnt_r, top_cnt_nxt;
  vgm_pkg::cnt_t   best_cnt_r, best_cnt_nxt;
  vgm_pkg::type_t  best_rep_r, best_rep_nxt;

  // Walk and sweep control.
  vgm_pkg::tot_t   walk_idx_r, walk_idx_nxt;
  logic            w1_v_r, w1_v_nxt;
  logic            w2_v_r, w2_v_nxt;
  vgm_pkg::type_t  w2_type_r;
  vgm_pkg::type_t  sweep_idx_r, sweep_idx_nxt;

  // Count RAM ports and forwarding.
  logic            cnt_we;
  vgm_pkg::type_t  cnt_waddr;
  vgm_pkg::cnt_t   cnt_wdata;
  vgm_pkg::type_t  cnt_raddr;
  vgm_pkg::cnt_t   cnt_rdata;
  vgm_pkg::type_t  cnt_raddr_q_r;
  logic            pw_v_r;
  vgm_pkg::type_t  pw_addr_r;
  vgm_pkg::cnt_t   pw_data_r;
  vgm_pkg::cnt_t   cnt_eff;

  // Seen-type RAM ports.
  logic                                 seen_we;
  logic [$clog2(vgm_pkg::SEEN_DEPTH)-1:0] seen_waddr;
  logic [$clog2(vgm_pkg::SEEN_DEPTH)-1:0] seen_raddr;
  vgm_pkg::type_t                       seen_rdata;

  // Output register.
  logic            out_v_r, out_v_nxt;
  vgm_pkg::type_t  out_type_r, out_type_nxt;
  logic            out_rule_r, out_rule_nxt;
  vgm_pkg::cnt_t   out_cnt_r, out_cnt_nxt;

  logic            in_acc;
  logic            walk_issue;
  logic            s1_new;
  logic            out_load;

  vgm_ram #(.WIDTH(vgm_pkg::CNT_W), .DEPTH(vgm_pkg::TYPE_DEPTH)) u_cnt_ram (
    .clk       (clk),
    .wr_en     (cnt_we),
    .wr_addr   (cnt_waddr),
    .wr_data   (cnt_wdata),
    .rd_addr   (cnt_raddr),
    .rd_data_r (cnt_rdata)
  );

  vgm_ram #(.WIDTH(vgm_pkg::TYPE_W), .DEPTH(vgm_pkg::SEEN_DEPTH)) u_seen_ram (
    .clk       (clk),
    .wr_en     (seen_we),
    .wr_addr   (seen_waddr),
    .wr_data   (s1_kind_r),
    .rd_addr   (seen_raddr),
    .rd_data_r (seen_rdata)
  );

  // Handshakes.
  assign in_if.ready = (state_r == vgm_pkg::ST_RUN) && !(s1_v_r && s1_last_r);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_if.valid               = out_v_r;
  assign out_if.representative_type = out_type_r;
  assign out_if.surface_rule_used   = out_rule_r;
  assign out_if.winning_count       = out_cnt_r;

  // A read issued in the cycle of a write to the same entry returns stale data.
  assign cnt_eff = (pw_v_r && (pw_addr_r == cnt_raddr_q_r)) ? pw_data_r : cnt_rdata;

  assign s1_new     = (cnt_eff == '0);
  assign walk_issue = (walk_idx_r < seen_total_r);
  assign seen_raddr = walk_idx_r[$clog2(vgm_pkg::SEEN_DEPTH)-1:0];
  assign seen_waddr = seen_total_r[$clog2(vgm_pkg::SEEN_DEPTH)-1:0];
  assign out_load   = (state_r == vgm_pkg::ST_DONE) && (!out_v_r || out_if.ready);

  // Count RAM read address.
  always_comb begin
    unique case (state_r)
      vgm_pkg::ST_RUN:  cnt_raddr = in_if.block_type;
      vgm_pkg::ST_WALK: cnt_raddr = seen_rdata;
      default:          cnt_raddr = top_kind_r;
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt      = state_r;
    s1_v_nxt       = in_acc;
    seen_total_nxt = seen_total_r;
    top_found_nxt  = top_found_r;
    top_layer_nxt  = top_layer_r;
    top_kind_nxt   = top_kind_r;
    ovf_nxt        = ovf_r;
    top_cnt_nxt    = top_cnt_r;
    best_cnt_nxt   = best_cnt_r;
    best_rep_nxt   = best_rep_r;
    walk_idx_nxt   = walk_idx_r;
    w1_v_nxt       = 1'b0;
    w2_v_nxt       = 1'b0;
    sweep_idx_nxt  = sweep_idx_r;
    cnt_we         = 1'b0;
    cnt_waddr      = sweep_idx_r;
    cnt_wdata      = '0;
    seen_we        = 1'b0;
    out_v_nxt      = out_v_r && !out_if.ready;
    out_type_nxt   = out_type_r;
    out_rule_nxt   = out_rule_r;
    out_cnt_nxt    = out_cnt_r;

    unique case (state_r)
      vgm_pkg::ST_CLR, vgm_pkg::ST_SWEEP: begin
        // Zero one count entry per cycle.
        cnt_we        = 1'b1;
        sweep_idx_nxt = sweep_idx_r + vgm_pkg::type_t'(1);
        if (sweep_idx_r == '1) begin
          state_nxt = (state_r == vgm_pkg::ST_CLR) ? vgm_pkg::ST_RUN : vgm_pkg::ST_DONE;
        end
      end
      vgm_pkg::ST_RUN: begin
        if (s1_v_r) begin
          // Count update, first-seen listing and top-layer tracking.
          if (s1_kind_r != vgm_pkg::AIR) begin
            cnt_we    = 1'b1;
            cnt_waddr = s1_kind_r;
            cnt_wdata = (cnt_eff == vgm_pkg::CNT_MAX) ? cnt_eff
                                                     : cnt_eff + vgm_pkg::cnt_t'(1);
            if (s1_new) begin
              if (seen_total_r < vgm_pkg::SEEN_FULL) begin
                seen_we        = 1'b1;
                seen_total_nxt = seen_total_r + vgm_pkg::tot_t'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            if (!top_found_r || (s1_layer_r > top_layer_r)) begin
              top_found_nxt = 1'b1;
              top_layer_nxt = s1_layer_r;
              top_kind_nxt  = s1_kind_r;
            end
          end
          if (s1_last_r) begin
            state_nxt = vgm_pkg::ST_TOPRD;
          end
        end
      end
      vgm_pkg::ST_TOPRD: begin
        state_nxt = vgm_pkg::ST_TOPCAP;
      end
      vgm_pkg::ST_TOPCAP: begin
        // Count of the top type, then start the mode walk.
        top_cnt_nxt  = cnt_eff;
        best_cnt_nxt = '0;
        best_rep_nxt = vgm_pkg::AIR;
        walk_idx_nxt = '0;
        state_nxt    = vgm_pkg::ST_WALK;
      end
      vgm_pkg::ST_WALK: begin
        // Three-step pipeline: list read, count read, compare and clear.
        if (walk_issue) begin
          w1_v_nxt     = 1'b1;
          walk_idx_nxt = walk_idx_r + vgm_pkg::tot_t'(1);
        end
        w2_v_nxt = w1_v_r;
        if (w2_v_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = w2_type_r;
          if (cnt_eff > best_cnt_r) begin
            best_cnt_nxt = cnt_eff;
            best_rep_nxt = w2_type_r;
          end
        end
        if (!walk_issue && !w1_v_r && !w2_v_r) begin
          sweep_idx_nxt = '0;
          state_nxt     = ovf_r ? vgm_pkg::ST_SWEEP : vgm_pkg::ST_DONE;
        end
      end
      vgm_pkg::ST_DONE: begin
        // Load the result once the output register is free, then clear the group.
        if (out_load) begin
          out_v_nxt = 1'b1;
          if (!top_found_r) begin
            out_type_nxt = vgm_pkg::AIR;
            out_rule_nxt = 1'b0;
            out_cnt_nxt  = '0;
          end else if (top_layer_r >= vgm_pkg::layer_t'(gs_r >> 1)) begin
            out_type_nxt = top_kind_r;
            out_rule_nxt = 1'b1;
            out_cnt_nxt  = top_cnt_r;
          end else begin
            out_type_nxt = best_rep_r;
            out_rule_nxt = 1'b0;
            out_cnt_nxt  = best_cnt_r;
          end
          seen_total_nxt = '0;
          top_found_nxt  = 1'b0;
          top_layer_nxt  = '0;
          top_kind_nxt   = vgm_pkg::AIR;
          ovf_nxt        = 1'b0;
          state_nxt      = vgm_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = vgm_pkg::ST_CLR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vgm_pkg::ST_CLR;
      gs_r         <= vgm_pkg::GS_RESET;
      s1_v_r       <= 1'b0;
      seen_total_r <= '0;
      top_found_r  <= 1'b0;
      top_layer_r  <= '0;
      top_kind_r   <= vgm_pkg::AIR;
      ovf_r        <= 1'b0;
      walk_idx_r   <= '0;
      w1_v_r       <= 1'b0;
      w2_v_r       <= 1'b0;
      sweep_idx_r  <= '0;
      pw_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_v_r       <= s1_v_nxt;
      seen_total_r <= seen_total_nxt;
      top_found_r  <= top_found_nxt;
      top_layer_r  <= top_layer_nxt;
      top_kind_r   <= top_kind_nxt;
      ovf_r        <= ovf_nxt;
      walk_idx_r   <= walk_idx_nxt;
      w1_v_r       <= w1_v_nxt;
      w2_v_r       <= w2_v_nxt;
      sweep_idx_r  <= sweep_idx_nxt;
      pw_v_r       <= cnt_we;
      out_v_r      <= out_v_nxt;
      // Group size is clamped to its legal range on write.
      if (cfg_we) begin
        if (cfg_wdata < vgm_pkg::GS_MIN) begin
          gs_r <= vgm_pkg::GS_MIN;
        end else if (cfg_wdata > vgm_pkg::GS_MAX) begin
          gs_r <= vgm_pkg::GS_MAX;
        end else begin
          gs_r <= cfg_wdata;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_if.block_type;
      s1_layer_r <= in_if.layer;
      s1_last_r  <= in_if.last_voxel;
    end
    top_cnt_r     <= top_cnt_nxt;
    best_cnt_r    <= best_cnt_nxt;
    best_rep_r    <= best_rep_nxt;
    w2_type_r     <= seen_rdata;
    cnt_raddr_q_r <= cnt_raddr;
    pw_addr_r     <= cnt_waddr;
    pw_data_r     <= cnt_wdata;
    out_type_r    <= out_type_nxt;
    out_rule_r    <= out_rule_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

endmodule
